>>> src/lag_pkg.sv
// ----------------------------------------------------------------------------
// lag_pkg: shared types and constants for the life generation block
// grid limits, configuration register codes, queue entry and snapshot types,
// and the b3/s23 cell rule
// ----------------------------------------------------------------------------
package lag_pkg;

  localparam int MAX_COLS   = 32;
  localparam int MAX_ROWS   = 1024;
  localparam int MIN_COLS   = 3;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int WIN_W      = 9;
  localparam int CNT_W      = 4;

  localparam logic [ROWS_CFG_W-1:0] RESET_GRID_ROWS = 11'd32;
  localparam logic [COLS_CFG_W-1:0] RESET_GRID_COLS = 6'd32;

  localparam logic [CNT_W-1:0] BIRTH_COUNT   = 4'd3;
  localparam logic [CNT_W-1:0] SURVIVE_COUNT = 4'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 2'd0,
    REG_GRID_COLS = 2'd1
  } cfg_reg_e;

  // effective grid geometry, already clamped
  typedef struct packed {
    logic [ROW_W-1:0] last_row;
    logic [COL_W-1:0] last_col;
  } geom_t;

  // one column of the 3x3 neighbourhood: [0] top, [1] middle, [2] bottom
  typedef logic [2:0] colv_t;

  // work handed from the front to the back for one accepted cell
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has0;
    logic             has1;
    logic             flush;
    logic [WIN_W-1:0] win0;
    logic [WIN_W-1:0] win1;
  } entry_t;

  // the last two rows of a frame, bit j is column j
  typedef struct packed {
    logic [MAX_COLS-1:0] above;
    logic [MAX_COLS-1:0] cur;
  } snap_t;

  typedef enum logic [1:0] {
    BK_HEAD,
    BK_SECOND,
    BK_BURST
  } back_state_e;

  // neighbourhood bit dy*3+dx, centre at bit 4
  function automatic logic [WIN_W-1:0] win9(colv_t l, colv_t m, colv_t r);
    return {r[2], m[2], l[2], r[1], m[1], l[1], r[0], m[0], l[0]};
  endfunction

  function automatic logic life_next(logic [WIN_W-1:0] w);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i != 4) n = n + {{(CNT_W-1){1'b0}}, w[i]};
    end
    return (n == BIRTH_COUNT) || (w[4] && (n == SURVIVE_COUNT));
  endfunction

endpackage

>>> src/lag_queue.sv
// ----------------------------------------------------------------------------
// lag_queue: short work queue between front and back
// register based fifo of entry words, head shown combinationally
// ----------------------------------------------------------------------------
module lag_queue import lag_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  entry_t               mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W_Q-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CNT_W_Q'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) count_d = count_q + CNT_W_Q'(1);
    else if (do_pop && !do_push) count_d = count_q - CNT_W_Q'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> src/lag_front.sv
// ----------------------------------------------------------------------------
// lag_front: cell intake and classification
// tracks raster position, keeps two line buffers and a column window, and
// turns each cell that has work into a queue entry; captures the last two rows at frame end
// ----------------------------------------------------------------------------
module lag_front import lag_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  geom_t  geom_i,
  input  logic   restart_i,
  input  logic   push_i,
  input  logic   alive_i,
  output logic   full_o,
  input  logic   q_full_i,
  output logic   q_push_o,
  output entry_t q_entry_o,
  input  logic   snap_take_i,
  output snap_t  snap_o
);

  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [MAX_COLS-1:0] l1_q, l1_d;
  logic [MAX_COLS-1:0] l2_q, l2_d;
  colv_t               w1_q, w2_q;
  snap_t               snap_q;
  logic                snap_full_q;

  logic  at_last_col, at_last_row, final_pos, accept;
  colv_t cur_v, left0;
  snap_t snap_d;

  assign at_last_col = (col_q == geom_i.last_col);
  assign at_last_row = (row_q == geom_i.last_row);
  assign final_pos   = at_last_col && at_last_row;
  assign full_o      = q_full_i || (final_pos && snap_full_q);
  assign accept      = push_i && !full_o;

  always_comb begin
    cur_v[0] = (row_q > ROW_W'(1)) ? l2_q[col_q] : 1'b0;
    cur_v[1] = l1_q[col_q];
    cur_v[2] = alive_i;
    left0    = (col_q > COL_W'(1)) ? w2_q : '0;

    l1_d        = l1_q;
    l1_d[col_q] = alive_i;
    l2_d        = l2_q;
    l2_d[col_q] = l1_q[col_q];

    snap_d.above = (row_q == '0) ? '0 : l2_d;
    snap_d.cur   = l1_d;

    q_entry_o.row   = row_q;
    q_entry_o.col   = col_q;
    q_entry_o.has0  = (row_q != '0) && (col_q != '0);
    q_entry_o.has1  = (row_q != '0) && at_last_col;
    q_entry_o.flush = final_pos;
    q_entry_o.win0  = win9(left0, w1_q, cur_v);
    q_entry_o.win1  = win9(w1_q, cur_v, '0);

    q_push_o = accept && (q_entry_o.has0 || q_entry_o.has1 || q_entry_o.flush);

    row_d = row_q;
    col_d = col_q;
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (final_pos) begin
        row_d = '0;
        col_d = '0;
      end else if (at_last_col) begin
        row_d = row_q + ROW_W'(1);
        col_d = '0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  assign snap_o = snap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      snap_full_q <= 1'b0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      if (accept && final_pos) snap_full_q <= 1'b1;
      else if (snap_take_i) snap_full_q <= 1'b0;
    end
  end

  // stale window contents from an earlier frame are masked at use
  always_ff @(posedge clk_i) begin
    if (accept) begin
      l1_q <= l1_d;
      l2_q <= l2_d;
      w1_q <= cur_v;
      w2_q <= w1_q;
      if (final_pos) snap_q <= snap_d;
    end
  end

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && final_pos |=> (row_q == '0) && (col_q == '0))
    else $error("position did not wrap after final cell");

  a_snap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_take_i |-> snap_full_q)
    else $error("snapshot taken while none captured");

endmodule

>>> src/lag_back.sv
// ----------------------------------------------------------------------------
// lag_back: rule evaluation and result sequencing
// works through queue entries, runs the final-row burst from the snapshot,
// tracks changes per frame and drives the output register
// ----------------------------------------------------------------------------
module lag_back import lag_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  geom_t            geom_i,
  input  logic             restart_i,
  input  logic             q_empty_i,
  input  entry_t           q_head_i,
  output logic             q_pop_o,
  input  snap_t            snap_i,
  output logic             snap_take_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             next_alive_o,
  output logic [ROW_W-1:0] cell_row_o,
  output logic [COL_W-1:0] cell_col_o,
  output logic             run_last_o,
  output logic             frame_end_o,
  output logic             unchanged_o
);

  back_state_e         state_q, state_d;
  logic [MAX_COLS-1:0] sa_q, sb_q;
  logic                pa_q, pb_q;
  logic [COL_W-1:0]    bcol_q;
  logic [ROW_W-1:0]    brow_q;
  logic                changed_q;
  logic                out_valid_q;

  logic             out_free, emit, load, shift;
  logic [WIN_W-1:0] e_win;
  logic [ROW_W-1:0] e_row;
  logic [COL_W-1:0] e_col;
  logic             e_last, e_frame, e_next, e_change, e_unchanged;
  logic             burst_end;

  assign out_free  = !out_valid_q || pop_i;
  assign burst_end = (bcol_q == geom_i.last_col);

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    emit    = 1'b0;
    load    = 1'b0;
    shift   = 1'b0;
    e_win   = '0;
    e_row   = '0;
    e_col   = '0;
    e_last  = 1'b0;
    e_frame = 1'b0;
    unique case (state_q)
      BK_HEAD: begin
        if (!q_empty_i && out_free) begin
          if (q_head_i.has0) begin
            emit   = 1'b1;
            e_win  = q_head_i.win0;
            e_row  = q_head_i.row - ROW_W'(1);
            e_col  = q_head_i.col - COL_W'(1);
            e_last = !q_head_i.has1 && !q_head_i.flush;
            if (q_head_i.has1) begin
              state_d = BK_SECOND;
            end else begin
              q_pop_o = 1'b1;
              if (q_head_i.flush) begin
                load    = 1'b1;
                state_d = BK_BURST;
              end
            end
          end else begin
            // single-row frame end: straight to the burst
            q_pop_o = 1'b1;
            if (q_head_i.flush) begin
              load    = 1'b1;
              state_d = BK_BURST;
            end
          end
        end
      end
      BK_SECOND: begin
        if (out_free) begin
          emit    = 1'b1;
          e_win   = q_head_i.win1;
          e_row   = q_head_i.row - ROW_W'(1);
          e_col   = q_head_i.col;
          e_last  = !q_head_i.flush;
          q_pop_o = 1'b1;
          if (q_head_i.flush) begin
            load    = 1'b1;
            state_d = BK_BURST;
          end else begin
            state_d = BK_HEAD;
          end
        end
      end
      BK_BURST: begin
        if (out_free) begin
          emit    = 1'b1;
          shift   = 1'b1;
          e_win   = win9({1'b0, pb_q, pa_q}, {1'b0, sb_q[0], sa_q[0]},
                         burst_end ? colv_t'(0) : {1'b0, sb_q[1], sa_q[1]});
          e_row   = brow_q;
          e_col   = bcol_q;
          e_last  = burst_end;
          e_frame = burst_end;
          if (burst_end) state_d = BK_HEAD;
        end
      end
      default: state_d = BK_HEAD;
    endcase
  end

  assign snap_take_o = load;
  assign e_next      = life_next(e_win);
  assign e_change    = (e_next != e_win[4]);
  assign e_unchanged = e_frame && !(changed_q || e_change);
  assign empty_o     = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_HEAD;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (restart_i) changed_q <= 1'b0;
      else if (emit && e_frame) changed_q <= 1'b0;
      else if (emit && e_change) changed_q <= 1'b1;
      if (emit) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      next_alive_o <= e_next;
      cell_row_o   <= e_row;
      cell_col_o   <= e_col;
      run_last_o   <= e_last;
      frame_end_o  <= e_frame;
      unchanged_o  <= e_unchanged;
    end
    if (load) begin
      sa_q   <= snap_i.above;
      sb_q   <= snap_i.cur;
      pa_q   <= 1'b0;
      pb_q   <= 1'b0;
      bcol_q <= '0;
      brow_q <= q_head_i.row;
    end else if (shift) begin
      pa_q   <= sa_q[0];
      pb_q   <= sb_q[0];
      sa_q   <= sa_q >> 1;
      sb_q   <= sb_q >> 1;
      bcol_q <= bcol_q + COL_W'(1);
    end
  end

  a_second_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SECOND |-> !q_empty_i)
    else $error("second result pending with empty queue");

  a_burst_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_BURST |-> bcol_q <= geom_i.last_col)
    else $error("burst column beyond grid");

  a_burst_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_BURST && out_free && burst_end |=> state_q == BK_HEAD)
    else $error("burst did not finish at last column");

endmodule

>>> src/life_automaton_generation_top.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_top: streaming game of life, rule b3/s23
// one generation per frame, cells in and results out in raster order
// ----------------------------------------------------------------------------
// order: a cell's result enters the output register once the back takes the entry
//   pushed when its lower-right neighbour is accepted, a row end's second result behind it;
//   the final row follows one a cycle while the output is free, after an idle load step
//   on a single row; throughput: one cell and one result word per cycle unless held by
//   full or a slow pop; a single-row grid adds its load step, so its intake can stall
// reset: grid 32 x 32, position at row 0 column 0, queue and output empty
// ----------------------------------------------------------------------------
module life_automaton_generation_top import lag_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // cell intake
  input  logic                  push,
  output logic                  full,
  input  logic                  cell_alive_i,
  // results
  output logic                  empty,
  input  logic                  pop,
  output logic                  next_alive_o,
  output logic [ROW_W-1:0]      cell_row_o,
  output logic [COL_W-1:0]      cell_col_o,
  output logic                  run_last_o,
  output logic                  frame_end_o,
  output logic                  unchanged_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration registers, as written
  logic [ROWS_CFG_W-1:0] grid_rows_q;
  logic [COLS_CFG_W-1:0] grid_cols_q;
  logic                  restart;

  // clamped geometry
  logic [ROWS_CFG_W-1:0] rows_eff, rows_m1;
  logic [COLS_CFG_W-1:0] cols_eff, cols_m1;
  geom_t                 geom;

  // front to queue to back
  logic   q_push, q_pop, q_full, q_empty;
  entry_t q_in, q_head;
  snap_t  snap;
  logic   snap_take;

  // a write to a known register restarts the frame
  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS: restart = 1'b1;
        REG_GRID_COLS: restart = 1'b1;
        default:       restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= RESET_GRID_ROWS;
      grid_cols_q <= RESET_GRID_COLS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        REG_GRID_COLS: grid_cols_q <= cfg_data_i[COLS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes are pinned to the nearest legal value
  always_comb begin
    priority if (grid_rows_q == '0) rows_eff = ROWS_CFG_W'(1);
    else if (grid_rows_q > ROWS_CFG_W'(MAX_ROWS)) rows_eff = ROWS_CFG_W'(MAX_ROWS);
    else rows_eff = grid_rows_q;

    priority if (grid_cols_q < COLS_CFG_W'(MIN_COLS)) cols_eff = COLS_CFG_W'(MIN_COLS);
    else if (grid_cols_q > COLS_CFG_W'(MAX_COLS)) cols_eff = COLS_CFG_W'(MAX_COLS);
    else cols_eff = grid_cols_q;

    rows_m1       = rows_eff - ROWS_CFG_W'(1);
    cols_m1       = cols_eff - COLS_CFG_W'(1);
    geom.last_row = rows_m1[ROW_W-1:0];
    geom.last_col = cols_m1[COL_W-1:0];
  end

  // front: position, line buffers, window, frame-end snapshot
  lag_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .restart_i   (restart),
    .push_i      (push),
    .alive_i     (cell_alive_i),
    .full_o      (full),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in),
    .snap_take_i (snap_take),
    .snap_o      (snap)
  );

  // work queue lets intake run on while results wait
  lag_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: rule, result order, change tracking, output register
  lag_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .restart_i    (restart),
    .q_empty_i    (q_empty),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .snap_i       (snap),
    .snap_take_o  (snap_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .next_alive_o (next_alive_o),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o),
    .unchanged_o  (unchanged_o)
  );

endmodule

>>> tb/life_automaton_generation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_generation_checker: next-generation predictor and scoreboard
// watches the cell intake, the result queue and the register port, predicts
// every result word from its own copy of the grid window and compares them
// ----------------------------------------------------------------------------
module life_automaton_generation_checker import lag_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  logic                  cell_alive_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  logic                  next_alive_i,
  input  logic [ROW_W-1:0]      cell_row_i,
  input  logic [COL_W-1:0]      cell_col_i,
  input  logic                  run_last_i,
  input  logic                  frame_end_i,
  input  logic                  unchanged_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int WINDOW_LEN = 2 * MAX_COLS + 3;

  typedef struct packed {
    logic             next_alive;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             run_last;
    logic             frame_end;
    logic             unchanged;
  } gen_word_t;

  gen_word_t             next_gen_q[$];
  logic [WINDOW_LEN-1:0] recent_cells;
  logic [ROWS_CFG_W-1:0] rows_reg;
  logic [COLS_CFG_W-1:0] cols_reg;
  int                    pos_row;
  int                    pos_col;
  bit                    changed_seen;

  function automatic int used_rows();
    if (rows_reg < 1) return 1;
    if (rows_reg > MAX_ROWS) return MAX_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic int used_cols();
    if (cols_reg < MIN_COLS) return MIN_COLS;
    if (cols_reg > MAX_COLS) return MAX_COLS;
    return int'(cols_reg);
  endfunction

  // state of cell (rr, cc) as seen from the newest cell (r, c)
  function automatic int cell_state(int rr, int cc, int r, int c, int rows, int cols);
    int off;
    if (rr < 0 || cc < 0 || rr >= rows || cc >= cols) return 0;
    off = (r - rr) * cols + (c - cc);
    if (off < 0 || off >= WINDOW_LEN) return 0;
    return int'(recent_cells[off]);
  endfunction

  task automatic resolve_cell(input int rr, input int cc, input int r, input int c,
                              input int rows, input int cols, output gen_word_t w);
    int cur;
    int count;
    int nxt;
    cur   = cell_state(rr, cc, r, c, rows, cols);
    count = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (dy != 0 || dx != 0) count += cell_state(rr + dy, cc + dx, r, c, rows, cols);
      end
    end
    nxt = cur ? ((count == 2 || count == 3) ? 1 : 0) : ((count == 3) ? 1 : 0);
    if (nxt != cur) changed_seen = 1'b1;
    w            = '0;
    w.next_alive = nxt[0];
    w.row        = rr[ROW_W-1:0];
    w.col        = cc[COL_W-1:0];
  endtask

  task automatic predict_generation(input logic alive);
    int        rows;
    int        cols;
    int        r;
    int        c;
    int        n;
    bit        last_cell;
    gen_word_t w;
    gen_word_t batch[$];
    rows = used_rows();
    cols = used_cols();
    if (pos_row >= rows || pos_col >= cols) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    recent_cells = {recent_cells[WINDOW_LEN-2:0], alive};
    last_cell = (r == rows - 1) && (c == cols - 1);
    if (r >= 1 && c >= 1) begin
      resolve_cell(r - 1, c - 1, r, c, rows, cols, w);
      batch.push_back(w);
    end
    if (r >= 1 && c == cols - 1) begin
      resolve_cell(r - 1, c, r, c, rows, cols, w);
      batch.push_back(w);
    end
    if (last_cell) begin
      for (int j = 0; j < cols; j++) begin
        resolve_cell(r, j, r, c, rows, cols, w);
        batch.push_back(w);
      end
    end
    n = batch.size();
    if (n > 0) begin
      w = batch[n-1];
      w.run_last = 1'b1;
      if (last_cell) begin
        w.frame_end = 1'b1;
        w.unchanged = !changed_seen;
      end
      batch[n-1] = w;
    end
    foreach (batch[i]) next_gen_q.push_back(batch[i]);
    if (last_cell) begin
      pos_row      = 0;
      pos_col      = 0;
      changed_seen = 1'b0;
    end else if (c == cols - 1) begin
      pos_col = 0;
      pos_row++;
    end else begin
      pos_col++;
    end
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_e'(idx))
      REG_GRID_ROWS: rows_reg = data[ROWS_CFG_W-1:0];
      REG_GRID_COLS: cols_reg = data[COLS_CFG_W-1:0];
      default: return;
    endcase
    pos_row      = 0;
    pos_col      = 0;
    changed_seen = 1'b0;
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got,
                                      gen_word_t w);
    if (want != got) begin
      $display("%0t ns: %s mismatch at row %0d col %0d, expected %0d, actual %0d",
               $time, name, w.row, w.col, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gen_word_t w;
    if (!rst_ni) begin
      next_gen_q.delete();
      recent_cells = '0;
      rows_reg     = RESET_GRID_ROWS;
      cols_reg     = RESET_GRID_COLS;
      pos_row      = 0;
      pos_col      = 0;
      changed_seen = 1'b0;
      fail_count_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) apply_reg_write(cfg_idx_i, cfg_data_i);
      if (push_i && !full_i) predict_generation(cell_alive_i);
      if (pop_i && !empty_i) begin
        if (next_gen_q.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual row %0d col %0d alive %0d",
                   $time, cell_row_i, cell_col_i, next_alive_i);
          fail_count_o++;
        end else begin
          w = next_gen_q.pop_front();
          check_field("next_alive", w.next_alive, next_alive_i, w);
          check_field("cell_row", w.row, cell_row_i, w);
          check_field("cell_col", w.col, cell_col_i, w);
          check_field("run_last", w.run_last, run_last_i, w);
          check_field("frame_end", w.frame_end, frame_end_i, w);
          check_field("unchanged", w.unchanged, unchanged_i, w);
          checked_o++;
        end
      end
    end
    pending_o = next_gen_q.size();
  end

endmodule

>>> tb/tb_life_automaton_generation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_automaton_generation_top: stimulus and verdict for the life block
// feeds short directed grids and then random grids of many sizes under four
// flow-control regimes; the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module tb_life_automaton_generation_top;
  import lag_pkg::*;

  // slack after the last word, covers an in-flight frame-end burst
  localparam int DRAIN_CYCLES = 64;
  // far above the slowest legal run of this stimulus
  localparam int CYCLE_LIMIT  = 600000;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS  = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic                  cell_alive_i;
  logic                  empty;
  logic                  pop = 1'b0;
  logic                  next_alive_o;
  logic [ROW_W-1:0]      cell_row_o;
  logic [COL_W-1:0]      cell_col_o;
  logic                  run_last_o;
  logic                  frame_end_o;
  logic                  unchanged_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int cells_sent;
  int grids_set;
  int idle_pct;
  int stall_pct;

  life_automaton_generation_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .cell_alive_i (cell_alive_i),
    .empty        (empty),
    .pop          (pop),
    .next_alive_o (next_alive_o),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o),
    .unchanged_o  (unchanged_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // predictor and scoreboard sit beside the block on the same wires
  life_automaton_generation_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .cell_alive_i (cell_alive_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .next_alive_i (next_alive_o),
    .cell_row_i   (cell_row_o),
    .cell_col_i   (cell_col_o),
    .run_last_i   (run_last_o),
    .frame_end_i  (frame_end_o),
    .unchanged_i  (unchanged_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog on the cycle counter
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
    $display("FAIL life_automaton_generation_top");
    $finish;
  end

  // receiver side: random stall on every cycle, rate set by the phase
  always @(negedge clk_i) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // cells held in a full frame once the hardware has clamped the geometry
  function automatic int frame_cells(logic [CFG_DATA_W-1:0] rows_data,
                                     logic [CFG_DATA_W-1:0] cols_data);
    int rows;
    int cols;
    rows = int'(rows_data[ROWS_CFG_W-1:0]);
    cols = int'(cols_data[COLS_CFG_W-1:0]);
    if (rows < 1) rows = 1;
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    if (cols < MIN_COLS) cols = MIN_COLS;
    if (cols > MAX_COLS) cols = MAX_COLS;
    return rows * cols;
  endfunction

  // one cell through the intake; entered and left at a falling edge, push high
  task automatic send_cell(input logic alive);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push         <= 1'b1;
    cell_alive_i <= alive;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    cells_sent++;
  endtask

  task automatic send_bits(input logic [15:0] bits, input int n);
    for (int i = 0; i < n; i++) send_cell(bits[i]);
  endtask

  // stop the intake and let every expected word come out
  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // each write ends on a falling edge with the enable low, so it never rises in the step it falls
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] rows_data,
                          input logic [CFG_DATA_W-1:0] cols_data);
    drain();
    write_reg(REG_GRID_ROWS, rows_data);
    write_reg(REG_GRID_COLS, cols_data);
    grids_set++;
  endtask

  task automatic send_random_cells(input int n, input int density);
    for (int i = 0; i < n; i++) send_cell($urandom_range(0, 99) < density);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] rows_data;
    logic [CFG_DATA_W-1:0] cols_data;
    int                    total;
    int                    count;
    int                    density;
    int                    sel;
    int                    phase_items;

    rst_ni       = 1'b0;
    push         = 1'b0;
    cell_alive_i = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_GRID_ROWS;
    cfg_data_i   = '0;
    cells_sent   = 0;
    grids_set    = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // two cells into the reset 32 x 32 grid, then dropped by a register write
    send_bits(16'b01, 2);
    // zero rows and zero columns clamp to a single row of three
    set_grid(11'd0, 11'd0);
    send_bits(16'b111, 3);
    // too few columns, single row again with a pair of live cells that both die
    set_grid(11'd1, 11'd2);
    send_bits(16'b110, 3);
    // blinker on a 3 x 3 grid, the vertical bar turns into the middle row
    set_grid(11'd3, 11'd3);
    send_bits(16'b010010010, 9);
    // a write to an index with no register behind it leaves the frame alone
    drain();
    write_reg(REG_UNUSED, 11'h7FF);
    send_bits(16'b000000000, 9);
    // dead single row, the unchanged flag should come up
    set_grid(11'd1, 11'd3);
    send_bits(16'b000, 3);

    // ---- random part, one flow-control regime per phase ----
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        sel = $urandom_range(0, 9);
        case (sel)
          0: cols_data = {5'($urandom), 6'd63};
          1: cols_data = {5'($urandom), 6'd32};
          2: cols_data = {5'($urandom), 6'($urandom_range(0, 2))};
          default: cols_data = {5'($urandom), 6'($urandom_range(3, 8))};
        endcase
        // wide grids stay short, narrow ones may run a few rows
        if (sel <= 1) rows_data = 11'($urandom_range(0, 2));
        else rows_data = 11'($urandom_range(0, 5));
        set_grid(rows_data, cols_data);

        total = frame_cells(rows_data, cols_data);
        // now and then a frame broken off part way by the next write
        count = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : total;
        sel = $urandom_range(0, 7);
        density = (sel == 0) ? 0 : (sel == 1) ? 100 : $urandom_range(20, 60);
        send_random_cells(count, density);
        phase_items += count;
      end
    end

    drain();
    $display("sent %0d cells over %0d grid settings, %0d result words checked",
             cells_sent, grids_set, checked);
    $display("grids from 1 x 3 up to 5 x 8 and 2 x 32, four stall regimes");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS life_automaton_generation_top");
    end else begin
      $display("FAIL life_automaton_generation_top");
    end
    $finish;
  end

endmodule
